// ===== rtl/ial_pkg.sv =====
// ---------------------------------------------------------------------------
// ial_pkg
// Shared types, codes and sizes for the indexed array list block.
// ---------------------------------------------------------------------------
package ial_pkg;

  // list sizing
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int REQ_W    = 3;
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 6;
  localparam int CNTO_W   = 7;
  localparam int STAT_W   = 2;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // request codes, 6 and 7 change nothing and give an OK result
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_OVERWRITE = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_DUMP      = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADIDX = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH,
    ST_DUMP_RD,
    ST_DUMP_EMIT
  } state_t;

  // one result item
  typedef struct packed {
    status_t            status;
    word_t              word;
    logic [IDX_W-1:0]   entry_index;
    logic [CNTO_W-1:0]  count_after;
    logic               last;
  } result_t;

  // store access from the sequencer
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  // shared index unit operands and results
  typedef struct packed {
    pos_t a;
    pos_t b;
    logic dec;
  } step_op_t;

  typedef struct packed {
    pos_t step;
    logic a_lt_b;
    logic a_gt_b;
    logic step_lt_b;
  } step_res_t;

endpackage

// ===== rtl/ial_step_unit.sv =====
// ---------------------------------------------------------------------------
// ial_step_unit
// Shared index unit: one increment or decrement and the compares that the
// sequencer needs for bounds checks and loop control.
// ---------------------------------------------------------------------------
module ial_step_unit (
  input  ial_pkg::step_op_t  op,
  output ial_pkg::step_res_t res
);
  import ial_pkg::*;

  // step by one in either direction
  always_comb begin
    res.step      = op.dec ? POS_W'(op.a - 1'b1) : POS_W'(op.a + 1'b1);
    res.a_lt_b    = (op.a < op.b);
    res.a_gt_b    = (op.a > op.b);
    res.step_lt_b = (res.step < op.b);
  end

endmodule

// ===== rtl/ial_store.sv =====
// ---------------------------------------------------------------------------
// ial_store
// Entry store: one write port and one read port with registered read data
// that holds until the next read.
// ---------------------------------------------------------------------------
module ial_store (
  input  logic              clk,
  input  ial_pkg::mem_req_t req,
  output ial_pkg::word_t    rd_data
);
  import ial_pkg::*;

  word_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/ial_seq.sv =====
// ---------------------------------------------------------------------------
// ial_seq
// Request sequencer: checks bounds, walks insert and delete shifts one
// entry at a time through the store, and steps through dumps.
// ---------------------------------------------------------------------------
module ial_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ial_pkg::REQ_W-1:0]     in_req,
  input  ial_pkg::pos_t                 in_pos,
  input  ial_pkg::word_t                in_word,
  input  logic                          out_free,
  output logic                          res_valid,
  output ial_pkg::result_t              res,
  output ial_pkg::mem_req_t             mem,
  input  ial_pkg::word_t                rd_data
);
  import ial_pkg::*;

  state_t    state, state_next;
  cnt_t      count, count_next;
  pos_t      idx, idx_next;
  req_t      req_q;
  pos_t      pos_q;
  word_t     word_q;
  pos_t      cnt_ext;
  logic      full;
  logic      is_insert;
  logic      exec_shift;
  logic      exec_dump;
  logic      exec_emits;
  logic      shift_cont;
  step_op_t  op;
  step_res_t sr;

  assign in_ready  = (state == ST_IDLE);
  assign cnt_ext   = POS_W'(count);
  assign full      = (count == CNT_W'(CAPACITY));
  assign is_insert = (req_q == REQ_INSERT);

  // operand select for the shared index unit
  always_comb begin
    op.a   = (state == ST_EXEC) ? pos_q : idx;
    op.b   = (state != ST_EXEC && is_insert) ? pos_q : cnt_ext;
    op.dec = (state != ST_EXEC) && is_insert;
  end

  ial_step_unit u_step (
    .op  (op),
    .res (sr)
  );

  // request decode in the execute state
  always_comb begin
    exec_shift = (is_insert && !sr.a_gt_b && !full) ||
                 (req_q == REQ_DELETE && sr.a_lt_b);
    exec_dump  = (req_q == REQ_DUMP) && (count != '0);
    exec_emits = !exec_shift && !exec_dump;
    shift_cont = is_insert ? sr.a_gt_b : sr.step_lt_b;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q  <= req_t'(in_req);
      pos_q  <= in_pos;
      word_q <= in_word;
    end
  end

  // state and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_shift)     state_next = ST_SHIFT_RD;
        else if (exec_dump) state_next = ST_DUMP_RD;
        else if (out_free)  state_next = ST_IDLE;
      end
      ST_SHIFT_RD: begin
        state_next = shift_cont ? ST_SHIFT_WR : ST_FINISH;
      end
      ST_SHIFT_WR: begin
        state_next = ST_SHIFT_RD;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_DUMP_RD: begin
        state_next = ST_DUMP_EMIT;
      end
      ST_DUMP_EMIT: begin
        if (out_free) state_next = sr.step_lt_b ? ST_DUMP_RD : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // count and loop index updates
  always_comb begin
    count_next = count;
    idx_next   = idx;
    unique case (state)
      ST_EXEC: begin
        if (exec_shift) begin
          idx_next = is_insert ? cnt_ext : pos_q;
        end else if (exec_dump) begin
          idx_next = '0;
        end else if (out_free) begin
          if (req_q == REQ_APPEND && !full) count_next = CNT_W'(count + 1'b1);
          if (req_q == REQ_CLEAR)           count_next = '0;
        end
      end
      ST_SHIFT_WR: begin
        idx_next = sr.step;
      end
      ST_FINISH: begin
        if (out_free) begin
          count_next = is_insert ? CNT_W'(count + 1'b1) : CNT_W'(count - 1'b1);
        end
      end
      ST_DUMP_EMIT: begin
        if (out_free) idx_next = sr.step;
      end
      default: ;
    endcase
  end

  // store access and result
  always_comb begin
    mem               = '0;
    res_valid         = 1'b0;
    res.status        = STAT_OK;
    res.word          = '0;
    res.entry_index   = '0;
    res.count_after   = CNTO_W'(count);
    res.last          = 1'b1;
    unique case (state)
      ST_EXEC: begin
        if (exec_emits && out_free) begin
          res_valid = 1'b1;
          case (req_q)
            REQ_APPEND: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                mem.wr_en       = 1'b1;
                mem.wr_addr     = count[ADDR_W-1:0];
                mem.wr_data     = word_q;
                res.word        = word_q;
                res.entry_index = IDX_W'(count);
                res.count_after = CNTO_W'(count + 1'b1);
              end
            end
            REQ_INSERT: begin
              res.status = sr.a_gt_b ? STAT_BADIDX : STAT_FULL;
            end
            REQ_OVERWRITE: begin
              if (!sr.a_lt_b) begin
                res.status = STAT_BADIDX;
              end else begin
                mem.wr_en       = 1'b1;
                mem.wr_addr     = pos_q[ADDR_W-1:0];
                mem.wr_data     = word_q;
                res.word        = word_q;
                res.entry_index = IDX_W'(pos_q);
              end
            end
            REQ_DELETE: res.status = STAT_BADIDX;
            REQ_DUMP:   res.status = STAT_EMPTY;
            REQ_CLEAR:  res.count_after = '0;
            default: ;
          endcase
        end
      end
      ST_SHIFT_RD: begin
        if (shift_cont) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = sr.step[ADDR_W-1:0];
        end
      end
      ST_SHIFT_WR: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx[ADDR_W-1:0];
        mem.wr_data = rd_data;
      end
      ST_FINISH: begin
        if (out_free) begin
          res_valid       = 1'b1;
          res.entry_index = IDX_W'(pos_q);
          if (is_insert) begin
            mem.wr_en       = 1'b1;
            mem.wr_addr     = pos_q[ADDR_W-1:0];
            mem.wr_data     = word_q;
            res.word        = word_q;
            res.count_after = CNTO_W'(count + 1'b1);
          end else begin
            res.count_after = CNTO_W'(count - 1'b1);
          end
        end
      end
      ST_DUMP_RD: begin
        mem.rd_en   = 1'b1;
        mem.rd_addr = idx[ADDR_W-1:0];
      end
      ST_DUMP_EMIT: begin
        if (out_free) begin
          res_valid       = 1'b1;
          res.word        = rd_data;
          res.entry_index = IDX_W'(idx);
          res.last        = !sr.step_lt_b;
        end
      end
      default: ;
    endcase
  end

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a result only goes out when the output register can take it
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result issued while output register busy");

  // writes never land beyond the first free cell
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    mem.wr_en |-> (CNT_W'(mem.wr_addr) <= count))
    else $error("store write beyond list end");

  // a finished insert grows the list by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && is_insert && out_free) |=>
      (count == CNT_W'($past(count) + 1'b1)))
    else $error("insert did not grow the list");

  // dumped entries lie inside the list
  a_dump_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP_EMIT) |-> (idx < cnt_ext))
    else $error("dump index outside list");

endmodule

// ===== rtl/indexed_array_list.sv =====
// ---------------------------------------------------------------------------
// indexed_array_list
// Bounded ordered list of signed 32-bit words with append, insert,
// overwrite, delete, dump and clear requests.
// ---------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_ channel, one per transaction; results leave on
//   the m_ channel. Every request gives one result with m_tlast set, except a
//   dump of a non-empty list, which gives one result per entry in index order
//   with m_tlast on the final one.
//   s_tready is high only while the sequencer is idle; one request is worked
//   on at a time. Append, overwrite, clear and all rejected requests give
//   their result from the execute state; insert and delete walk the shift
//   read and write states one entry at a time, then the finish state; a
//   dump reads and emits each entry in turn. Each shifted entry is read
//   from the store and then written to its new place. The sequencer
//   returns to idle before the next acceptance.
//   Results sit in an output register; when the receiver stalls the
//   sequencer waits with its next result and holds off new requests.
//   Reset (rst, synchronous) empties the list and drops any pending result.
// ---------------------------------------------------------------------------
module indexed_array_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], word_in[38:7]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // word_out[31:0], entry_index[37:32], count_after[44:38]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);
  import ial_pkg::*;

  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  res_q;
  mem_req_t mem;
  word_t    rd_data;

  assign out_free = !m_tvalid || m_tready;

  ial_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_pos    (s_tdata[6:0]),
    .in_word   (s_tdata[38:7]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem       (mem),
    .rd_data   (rd_data)
  );

  ial_store u_store (
    .clk     (clk),
    .req     (mem),
    .rd_data (rd_data)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  // result packing
  assign m_tdata = {3'b000, res_q.count_after, res_q.entry_index, res_q.word};
  assign m_tuser = res_q.status;
  assign m_tlast = res_q.last;

endmodule
